// ===== hw/rtl/byte_stream_tokenizer_assert.svh =====
// Assertion macros for the byte stream tokenizer.
`ifndef BYTE_STREAM_TOKENIZER_ASSERT_SVH
`define BYTE_STREAM_TOKENIZER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define BST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger is followed on the next edge by a consequence.
`define BST_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bst_pkg.sv =====
package bst_pkg;

  // Default width of the position counter.
  localparam int unsigned PositionBitsDef = 16;

  // Depth of the token queue in front of the output channel.
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_IDENT  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_EQ     = 3'd3,
    MODE_HALT   = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    TOK_IDENT  = 4'd0,
    TOK_INT    = 4'd1,
    TOK_EQUALS = 4'd2,
    TOK_ARROW  = 4'd3,
    TOK_LPAREN = 4'd4,
    TOK_RPAREN = 4'd5,
    TOK_LBRACE = 4'd6,
    TOK_RBRACE = 4'd7,
    TOK_COLON  = 4'd8,
    TOK_COMMA  = 4'd9,
    TOK_LT     = 4'd10,
    TOK_GT     = 4'd11,
    TOK_SEMI   = 4'd12,
    TOK_EOF    = 4'd13,
    TOK_ERROR  = 4'd14
  } tok_e;

  // Byte codes the classifier looks for.
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChGt    = 8'h3E;

  typedef struct packed {
    tok_e        ttype;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  // Up to two tokens produced by one byte, in output order.
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } tok_pair_t;

  typedef struct packed {
    mode_e mode;
  } core_stat_t;

  function automatic logic is_letter(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c inside {ChCr, ChLf, ChSpace, ChTab};
  endfunction

  // Single-byte punctuation: valid flag in the top bit, token type below.
  function automatic logic [4:0] punct_lookup(logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h28:   r = {1'b1, TOK_LPAREN};
      8'h29:   r = {1'b1, TOK_RPAREN};
      8'h7B:   r = {1'b1, TOK_LBRACE};
      8'h7D:   r = {1'b1, TOK_RBRACE};
      8'h3A:   r = {1'b1, TOK_COLON};
      8'h2C:   r = {1'b1, TOK_COMMA};
      8'h3C:   r = {1'b1, TOK_LT};
      8'h3E:   r = {1'b1, TOK_GT};
      8'h3B:   r = {1'b1, TOK_SEMI};
      default: r = {1'b0, TOK_ERROR};
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/bst_core.sv =====
module bst_core #(
  parameter int unsigned POSITION_BITS = bst_pkg::PositionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          ch_i,
  output bst_pkg::tok_pair_t  toks_o,
  output bst_pkg::core_stat_t stat_o
);
  import bst_pkg::*;

  mode_e                    mode_q, mode_d;
  logic [15:0]              run_start_q, run_start_d;
  logic [15:0]              run_len_q, run_len_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [15:0]              pos16;
  logic [15:0]              run_len_inc;
  logic                     pre_v, byte_v, handle_byte;
  tok_t                     pre_tok, byte_tok;
  logic [4:0]               punct;

  // Saturating increments
  assign pos_inc     = (&pos_q) ? pos_q : pos_q + POSITION_BITS'(1);
  assign run_len_inc = (&run_len_q) ? run_len_q : run_len_q + 16'd1;
  assign punct       = punct_lookup(ch_i);

  // Position seen through a 16-bit saturating window
  if (POSITION_BITS > 16) begin : g_pos_wide
    assign pos16 = (|pos_q[POSITION_BITS-1:16]) ? 16'hFFFF : pos_q[15:0];
  end else begin : g_pos_narrow
    assign pos16 = 16'(pos_q);
  end

  // Extend or close any open run or pending '='; a byte not used up by that is classified as in idle
  always_comb begin
    mode_d      = mode_q;
    run_start_d = run_start_q;
    run_len_d   = run_len_q;
    pos_d       = pos_q;
    pre_v       = 1'b0;
    pre_tok     = '{ttype: TOK_IDENT, start: run_start_q, len: run_len_q, last: 1'b0};
    byte_v      = 1'b0;
    byte_tok    = '{ttype: TOK_ERROR, start: pos16, len: 16'd1, last: 1'b0};
    handle_byte = 1'b0;

    case (mode_q)
      MODE_IDENT, MODE_NUMBER: begin
        if (is_digit(ch_i) || (mode_q == MODE_IDENT && is_letter(ch_i))) begin
          run_len_d = run_len_inc;
          pos_d     = pos_inc;
        end else begin
          pre_v         = 1'b1;
          pre_tok.ttype = (mode_q == MODE_IDENT) ? TOK_IDENT : TOK_INT;
          mode_d        = MODE_IDLE;
          handle_byte   = 1'b1;
        end
      end
      MODE_EQ: begin
        pre_v  = 1'b1;
        mode_d = MODE_IDLE;
        if (ch_i == ChGt) begin
          pre_tok.ttype = TOK_ARROW;
          pre_tok.len   = 16'd2;
          pos_d         = pos_inc;
        end else begin
          pre_tok.ttype = TOK_EQUALS;
          pre_tok.len   = 16'd1;
          handle_byte   = 1'b1;
        end
      end
      MODE_IDLE: handle_byte = 1'b1;
      default: ;
    endcase

    if (handle_byte) begin
      if (ch_i == ChNul) begin
        byte_v         = 1'b1;
        byte_tok.ttype = TOK_EOF;
        byte_tok.len   = 16'd0;
        pos_d          = '0;
      end else if (is_blank(ch_i)) begin
        pos_d = pos_inc;
      end else if (is_letter(ch_i) || is_digit(ch_i) || ch_i == ChEq) begin
        mode_d      = is_letter(ch_i) ? MODE_IDENT :
                      (is_digit(ch_i) ? MODE_NUMBER : MODE_EQ);
        run_start_d = pos16;
        run_len_d   = 16'd1;
        pos_d       = pos_inc;
      end else if (punct[4]) begin
        byte_v         = 1'b1;
        byte_tok.ttype = tok_e'(punct[3:0]);
        pos_d          = pos_inc;
      end else begin
        byte_v = 1'b1;
        mode_d = MODE_HALT;
      end
    end
  end

  // Order the tokens and mark the final one
  always_comb begin
    toks_o    = '0;
    toks_o.v0 = step_i && (pre_v || byte_v);
    toks_o.v1 = step_i && pre_v && byte_v;
    toks_o.t0 = pre_v ? pre_tok : byte_tok;
    toks_o.t1 = byte_tok;
    toks_o.t0.last = !(pre_v && byte_v);
    toks_o.t1.last = 1'b1;
  end

  assign stat_o.mode = mode_q;

  // Advance state on each processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      run_start_q <= '0;
      run_len_q   <= '0;
      pos_q       <= '0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      run_start_q <= run_start_d;
      run_len_q   <= run_len_d;
      pos_q       <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/bst_queue.sv =====
module bst_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bst_pkg::tok_pair_t toks_i,
  output logic               room_o,
  output logic [$clog2(bst_pkg::QueueDepth):0] level_o,
  output logic               valid_o,
  input  logic               ready_i,
  output bst_pkg::tok_t      tok_o
);
  import bst_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = PtrW + 1;

  tok_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nxt;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);
  assign pop        = valid_o && ready_i;
  assign valid_o    = cnt_q != '0;
  assign room_o     = cnt_q <= CntW'(QueueDepth - 2);
  assign level_o    = cnt_q;
  assign tok_o      = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(toks_i.v0) + PtrW'(toks_i.v1);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(toks_i.v0) + CntW'(toks_i.v1) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store up to two tokens per cycle
  always_ff @(posedge clk_i) begin
    if (toks_i.v0) begin
      mem_q[wr_ptr_q] <= toks_i.t0;
    end
    if (toks_i.v1) begin
      mem_q[wr_ptr_nxt] <= toks_i.t1;
    end
  end

endmodule

// ===== hw/rtl/byte_stream_tokenizer.sv =====
// Byte stream tokenizer.
// Slave channel: one source byte per word on s_axis_tdata_i; byte 0 ends the
// text. Master channel: one token per word, with type, start position and
// length; tlast marks the final token caused by one source byte.
// An accepted byte waits in the input register, is classified by the core and
// its tokens are written to the token queue, which drives the master side.
// Throughput: one byte per cycle while the token queue has room. A byte that
// closes an identifier, number or pending '=' and also makes a token of its
// own yields two tokens, which the single-word master side sends one after the
// other; the four-entry token queue absorbs this and holds tready low only
// while fewer than two entries are free.
// Reset clears the mode, position and run counters and empties the queue.
// When the receiver stalls, tokens wait in the queue and the input register
// holds its byte; tready falls once the queue cannot take two more tokens.
// After an error token every byte is taken and dropped until reset.
module byte_stream_tokenizer #(
  parameter int unsigned POSITION_BITS = bst_pkg::PositionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [3:0] token_type, [19:4] start_pos,
                                        // [35:20] length, [39:36] zero
  output logic        m_axis_tlast_o
);
  import bst_pkg::*;

`include "byte_stream_tokenizer_assert.svh"

  logic                              in_valid_q;
  logic [7:0]                        in_byte_q;
  logic                              room, step;
  logic [$clog2(QueueDepth):0]       level;
  tok_pair_t                         toks;
  core_stat_t                        stat;
  tok_t                              out_tok;

  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  bst_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .ch_i  (in_byte_q),
    .toks_o(toks),
    .stat_o(stat)
  );

  bst_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .toks_i (toks),
    .room_o (room),
    .level_o(level),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .tok_o  (out_tok)
  );

  assign m_axis_tdata_o = {4'd0, out_tok.len, out_tok.start, out_tok.ttype};
  assign m_axis_tlast_o = out_tok.last;

  `BST_ASSERT(a_level_bound, level <= ($clog2(QueueDepth) + 1)'(QueueDepth),
    "token queue overflow")
  `BST_ASSERT(a_pair_order, !toks.v1 || toks.v0, "second token without first")
  `BST_ASSERT(a_halt_silent, !(stat.mode == MODE_HALT && toks.v0),
    "token produced while halted")
  `BST_ASSERT_NEXT(a_halt_sticky, stat.mode == MODE_HALT, stat.mode == MODE_HALT,
    "left halted mode without reset")

endmodule

// ===== sim/byte_stream_tokenizer_checker.sv =====
module byte_stream_tokenizer_checker #(
  parameter int unsigned POSITION_BITS = bst_pkg::PositionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int unsigned mismatch_count_o,
  output int unsigned tokens_pending_o
);
  import bst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned PosMax = (64'd1 << POSITION_BITS) - 64'd1;
  localparam logic [15:0] LenMax = 16'hFFFF;

  // Lexer state mirrored from the byte side
  mode_e           lex_mode   = MODE_IDLE;
  logic [15:0]     run_origin = '0;
  logic [15:0]     run_count  = '0;
  longint unsigned byte_pos   = 0;

  // Tokens still owed by the block, oldest first
  tok_t expected_tokens[$];

  function automatic logic [15:0] clamp16(longint unsigned v);
    return (v > 64'hFFFF) ? LenMax : 16'(v);
  endfunction

  function automatic logic alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Map a single-byte punctuation mark to its token; error when not one
  function automatic tok_e punct_kind(logic [7:0] c);
    case (c)
      "(":     return TOK_LPAREN;
      ")":     return TOK_RPAREN;
      "{":     return TOK_LBRACE;
      "}":     return TOK_RBRACE;
      ":":     return TOK_COLON;
      ",":     return TOK_COMMA;
      "<":     return TOK_LT;
      ">":     return TOK_GT;
      ";":     return TOK_SEMI;
      default: return TOK_ERROR;
    endcase
  endfunction

  function automatic tok_t make_token(tok_e kind, logic [15:0] origin, logic [15:0] count);
    tok_t t;
    t.ttype = kind;
    t.start = origin;
    t.len   = count;
    t.last  = 1'b0;
    return t;
  endfunction

  function automatic void bump_pos();
    if (byte_pos < PosMax) byte_pos++;
  endfunction

  // Advance the lexer by one byte and queue the tokens it produces
  function automatic void predict_tokens(logic [7:0] c);
    tok_t toks[2];
    int   n;
    logic arrow_done;
    logic keep_run;
    tok_e kind;
    n = 0;
    arrow_done = 1'b0;
    if (lex_mode == MODE_HALT) return;

    // Extend or close an open run, or close a pending '='
    if (lex_mode == MODE_IDENT || lex_mode == MODE_NUMBER) begin
      keep_run = (lex_mode == MODE_IDENT) ? (alpha(c) || numeral(c)) : numeral(c);
      if (keep_run) begin
        if (run_count != LenMax) run_count++;
        bump_pos();
        return;
      end
      toks[n] = make_token((lex_mode == MODE_IDENT) ? TOK_IDENT : TOK_INT,
                           run_origin, run_count);
      n++;
      lex_mode = MODE_IDLE;
    end else if (lex_mode == MODE_EQ) begin
      lex_mode = MODE_IDLE;
      if (c == ChGt) begin
        toks[n] = make_token(TOK_ARROW, run_origin, 16'd2);
        n++;
        bump_pos();
        arrow_done = 1'b1;
      end else begin
        toks[n] = make_token(TOK_EQUALS, run_origin, 16'd1);
        n++;
      end
    end

    // Classify the byte from idle
    if (!arrow_done) begin
      kind = punct_kind(c);
      if (c == ChNul) begin
        toks[n] = make_token(TOK_EOF, clamp16(byte_pos), 16'd0);
        n++;
        byte_pos = 0;
      end else if (c == ChCr || c == ChLf || c == ChSpace || c == ChTab) begin
        bump_pos();
      end else if (alpha(c) || numeral(c) || c == ChEq) begin
        lex_mode   = alpha(c) ? MODE_IDENT : (numeral(c) ? MODE_NUMBER : MODE_EQ);
        run_origin = clamp16(byte_pos);
        run_count  = 16'd1;
        bump_pos();
      end else if (kind != TOK_ERROR) begin
        toks[n] = make_token(kind, clamp16(byte_pos), 16'd1);
        n++;
        bump_pos();
      end else begin
        toks[n] = make_token(TOK_ERROR, clamp16(byte_pos), 16'd1);
        n++;
        lex_mode = MODE_HALT;
      end
    end

    for (int i = 0; i < n; i++) begin
      toks[i].last = (i == n - 1);
      expected_tokens.push_back(toks[i]);
    end
  endfunction

  // Compare one token word against the oldest expectation
  function automatic void check_token();
    tok_t want;
    logic [3:0]  got_type;
    logic [15:0] got_start;
    logic [15:0] got_len;
    logic [3:0]  got_pad;
    got_type  = m_tdata_i[3:0];
    got_start = m_tdata_i[19:4];
    got_len   = m_tdata_i[35:20];
    got_pad   = m_tdata_i[39:36];
    if (expected_tokens.size() == 0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("%0t: unexpected token: type %0d start %0d len %0d last %0b",
                 $realtime, got_type, got_start, got_len, m_tlast_i);
      return;
    end
    want = expected_tokens.pop_front();
    if (got_type !== want.ttype || got_start !== want.start || got_len !== want.len ||
        m_tlast_i !== want.last || got_pad !== 4'd0) begin
      mismatch_count_o++;
      if (mismatch_count_o <= 10)
        $display("%0t: token mismatch: expected type %0d start %0d len %0d last %0b, got %s",
                 $realtime, want.ttype, want.start, want.len, want.last,
                 $sformatf("type %0d start %0d len %0d last %0b pad %h",
                           got_type, got_start, got_len, m_tlast_i, got_pad));
    end
  endfunction

  // Watch both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lex_mode         = MODE_IDLE;
      run_origin       = '0;
      run_count        = '0;
      byte_pos         = 0;
      mismatch_count_o = 0;
      expected_tokens.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) check_token();
      if (s_tvalid_i && s_tready_i) predict_tokens(s_tdata_i);
    end
    tokens_pending_o = expected_tokens.size();
  end

endmodule

// ===== sim/byte_stream_tokenizer_tb.sv =====
module byte_stream_tokenizer_tb;

  import bst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;   // [3:0] token_type, [19:4] start_pos, [35:20] length, [39:36] zero
  logic        m_tlast;

  int unsigned mismatches;
  int unsigned tokens_pending;
  int unsigned words_sent = 0;
  bit          tx_burst = 1'b0;
  bit          tx_hold_burst = 1'b0;
  bit          rx_burst = 1'b0;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  byte_stream_tokenizer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  byte_stream_tokenizer_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_tvalid_i       (s_tvalid),
    .s_tready_i       (s_tready),
    .s_tdata_i        (s_tdata),
    .m_tvalid_i       (m_tvalid),
    .m_tready_i       (m_tready),
    .m_tdata_i        (m_tdata),
    .m_tlast_i        (m_tlast),
    .mismatch_count_o (mismatches),
    .tokens_pending_o (tokens_pending)
  );

  // Send one byte word after a random gap; returns at the falling edge
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (!tx_hold_burst && $urandom_range(0, 40) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return $urandom_range(0, 2) == 0 ? rand_digit() : rand_letter();
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 3))
      0:       return ChCr;
      1:       return ChLf;
      2:       return ChTab;
      default: return ChSpace;
    endcase
  endfunction

  function automatic logic [7:0] rand_punct();
    string marks;
    marks = "(){}:,<>;";
    return marks[$urandom_range(0, 8)];
  endfunction

  // Any byte that keeps the lexer running
  function automatic logic [7:0] rand_legal();
    case ($urandom_range(0, 6))
      0:       return rand_letter();
      1:       return rand_digit();
      2:       return rand_blank();
      3:       return ChEq;
      4:       return rand_punct();
      5:       return ($urandom_range(0, 9) == 0) ? ChNul : ChGt;
      default: return rand_alnum();
    endcase
  endfunction

  // Accept token words with random stalls and stretches without any
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 30) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned first_word;
    int unsigned pick;
    int unsigned count;
    string odd_marks;
    odd_marks = "!#$%&*+-./?@[]^_|~";

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every token kind but the error token, run closing, lookahead and blanks
    push_text("Az9");
    push_byte(ChTab);
    push_text("42x=>=(");
    push_byte(ChCr);
    push_byte(ChLf);
    push_text("){}:,<>;==0 ");
    push_byte(ChNul);

    // Long identifier run sent back to back
    tx_hold_burst = 1'b1;
    tx_burst = 1'b1;
    push_byte(rand_letter());
    repeat (150) push_byte(rand_alnum());
    push_text(" (=>");
    push_byte(rand_blank());
    push_text("7=");
    push_byte(ChNul);
    tx_hold_burst = 1'b0;
    tx_burst = 1'b0;

    // Random well-formed text with a share of loose legal bytes
    first_word = words_sent;
    while (words_sent - first_word < 800) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        push_byte(rand_letter());
        repeat ($urandom_range(0, 7)) push_byte(rand_alnum());
      end else if (pick < 45) begin
        repeat ($urandom_range(1, 5)) push_byte(rand_digit());
      end else if (pick < 55) begin
        push_byte(ChEq);
      end else if (pick < 62) begin
        push_text("=>");
      end else if (pick < 75) begin
        push_byte(rand_punct());
      end else if (pick < 85) begin
        push_byte(rand_blank());
      end else if (pick < 88) begin
        push_byte(ChNul);
      end else begin
        count = $urandom_range(1, 4);
        repeat (count) push_byte(rand_legal());
      end
    end

    // Error byte, then bytes that the halted block must drop
    if ($urandom_range(0, 1)) push_byte(8'($urandom_range(128, 255)));
    else push_byte(odd_marks[$urandom_range(0, odd_marks.len() - 1)]);
    push_byte(8'hFF);
    push_byte(ChNul);
    push_text("ab=>(");
    repeat (15) push_byte(8'($urandom_range(0, 255)));
    s_tvalid <= 1'b0;

    // Drain and let any stray token show up
    while (tokens_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== byte_stream_tokenizer.f =====
+incdir+hw/rtl
hw/rtl/bst_pkg.sv
hw/rtl/bst_core.sv
hw/rtl/bst_queue.sv
hw/rtl/byte_stream_tokenizer.sv
sim/byte_stream_tokenizer_checker.sv
sim/byte_stream_tokenizer_tb.sv
